>>> rtl/core/lest_pkg.sv
// ----------------------------------------------------------------------------
// Lock event statistics table package
// Shared types, sizes and codes of the statistics table.
// ----------------------------------------------------------------------------
package lest_pkg;

	localparam int RECORDS      = 1024;
	localparam int HASH_BUCKETS = 2048;
	localparam int NUM_EVENTS   = 64;
	localparam int HIST_BINS    = 64;

	localparam int SLOT_W = $clog2(RECORDS);
	localparam int LINK_W = $clog2(RECORDS + 1);
	localparam int BKT_W  = $clog2(HASH_BUCKETS);
	localparam int BIN_W  = $clog2(HIST_BINS);
	localparam int HADR_W = SLOT_W + BIN_W;
	localparam int EVT_W  = $clog2(NUM_EVENTS) > 0 ? $clog2(NUM_EVENTS) : 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DAT_W = 11;

	localparam logic [1:0] FUNC_RECORD = 2'd0;
	localparam logic [1:0] FUNC_THRESH = 2'd1;
	localparam logic [1:0] FUNC_READ   = 2'd2;
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	localparam logic [1:0] MODE_COUNT = 2'd0;
	localparam logic [1:0] MODE_TIME  = 2'd1;
	localparam logic [1:0] MODE_HIST  = 2'd2;

	localparam logic [2:0] ST_UPDATED  = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_BELOW    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_THRESH   = 3'd4;
	localparam logic [2:0] ST_READ     = 3'd5;

	localparam logic CFG_MODE  = 1'b0;
	localparam logic CFG_LIMIT = 1'b1;

	typedef struct packed {
		logic [1:0]  func;
		logic [63:0] lock_addr;
		logic [63:0] caller;
		logic [5:0]  event_req;
		logic [31:0] ref_count;
		logic [62:0] duration;
		logic [62:0] threshold_value;
		logic [9:0]  record_index;
		logic [5:0]  hist_bin;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [63:0] out_lock;
		logic [63:0] out_caller;
		logic [5:0]  out_event;
		logic [31:0] out_count;
		logic [63:0] out_refcnt;
		logic [63:0] out_time;
		logic [31:0] out_hist;
		logic [10:0] records_in_use;
		logic [31:0] fail_total;
	} rsp_t;

	typedef enum logic [3:0] {
		CMD_NONE  = 4'b0001,
		CMD_HEAD  = 4'b0010,
		CMD_WALK  = 4'b0100,
		CMD_WRITE = 4'b1000
	} cmd_op_t;

	typedef struct packed {
		logic    load;
		cmd_op_t op;
		logic    clear;
	} cmd_t;

	typedef struct packed {
		logic clear_done;
		logic below;
		logic link_end;
		logic hit;
		logic is_other;
	} sts_t;

	function automatic logic [BIN_W-1:0] log2_bin(input logic [62:0] v);
		logic [BIN_W-1:0] b;
		b = '0;
		for (int i = 1; i < 63; i++) begin
			if (v[i]) begin
				b = BIN_W'(i);
			end
		end
		return b;
	endfunction

endpackage

>>> rtl/core/lock_event_stat_table_top.sv
// ----------------------------------------------------------------------------
// Lock event statistics table
// Profiling counters per lock and caller, kept in chains hashed on lock, caller and event.
// ----------------------------------------------------------------------------
// Usage: raise start with an item on req while busy is low; the item is taken
// at that edge. One result item appears on rsp with done high for a single
// cycle, for each item except one with the unused code; the receiver cannot
// stall and must take it then. Configuration is written through cfg_we,
// cfg_idx and cfg_data; the user must do so only while no item is in flight,
// as the block does not enforce it. Threshold writes, reads and
// below-threshold events go from the head state straight to the write state.
// A record event reads the bucket head, waits on the registered read of the
// record memories and compares, again for each chain entry passed over
// without a match. A new item can be taken at the edge that ends the done
// cycle. After reset a clearing pass runs over the histogram store, one entry
// a cycle, which also clears the bucket heads and the threshold table; busy
// stays high for its length, while configuration writes are taken.
// ----------------------------------------------------------------------------
module lock_event_stat_table_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  lest_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output lest_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic           cfg_idx,
	input  logic [10:0]    cfg_data
);
	import lest_pkg::*;

	cmd_t cmd;
	sts_t sts;
	rsp_t result;
	logic result_valid;

	lest_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
	);

	lest_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data), .req(req), .cmd(cmd), .sts(sts),
		.result(result), .result_valid(result_valid)
	);

	rsp_t rsp_q;
	always_ff @(posedge clk) begin
		if (cmd.op == CMD_WRITE) begin
			rsp_q <= result;
		end
	end
	assign rsp  = rsp_q;
	assign done = result_valid;
endmodule

>>> rtl/core/lest_ctrl.sv
// ----------------------------------------------------------------------------
// Lock event statistics table controller
// Sequences the clearing pass, the chain walk, the record update and the threshold write.
// ----------------------------------------------------------------------------
module lest_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  lest_pkg::sts_t sts,
	output logic          busy,
	output lest_pkg::cmd_t cmd
);
	import lest_pkg::*;

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_HEAD  = 6'b000100,
		S_WAIT  = 6'b001000,
		S_WALK  = 6'b010000,
		S_WRITE = 6'b100000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd.load  = 1'b0;
		cmd.op    = CMD_NONE;
		cmd.clear = 1'b0;
		busy      = 1'b1;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_done) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_HEAD;
				end
			end
			S_HEAD: begin
				if (sts.is_other || sts.below) begin
					state_d = S_WRITE;
				end else begin
					cmd.op  = CMD_HEAD;
					state_d = S_WAIT;
				end
			end
			S_WAIT: begin
				state_d = S_WALK;
			end
			S_WALK: begin
				if (sts.link_end || sts.hit) begin
					state_d = S_WRITE;
				end else begin
					cmd.op  = CMD_WALK;
					state_d = S_WAIT;
				end
			end
			S_WRITE: begin
				cmd.op  = CMD_WRITE;
				state_d = S_IDLE;
			end
			default: state_d = S_CLEAR;
		endcase
	end
endmodule

>>> rtl/core/lest_dp.sv
// ----------------------------------------------------------------------------
// Lock event statistics table datapath
// Record memories, bucket heads, histogram store, threshold table and counters.
// ----------------------------------------------------------------------------
module lest_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic           cfg_idx,
	input  logic [10:0]    cfg_data,
	input  lest_pkg::req_t req,
	input  lest_pkg::cmd_t cmd,
	output lest_pkg::sts_t sts,
	output lest_pkg::rsp_t result,
	output logic           result_valid
);
	import lest_pkg::*;

	logic [LINK_W-1:0] head_mem [HASH_BUCKETS];
	logic [LINK_W-1:0] link_mem [RECORDS];
	logic [63:0]       lock_mem [RECORDS];
	logic [63:0]       call_mem [RECORDS];
	logic [5:0]        evt_mem  [RECORDS];
	logic [31:0]       cnt_mem  [RECORDS];
	logic [63:0]       ref_mem  [RECORDS];
	logic [63:0]       time_mem [RECORDS];
	logic [31:0]       hist_mem [RECORDS*HIST_BINS];
	logic [62:0]       thr_mem  [NUM_EVENTS];

	logic [1:0]        mode_q;
	logic [10:0]       limit_q;
	logic [10:0]       alloc_q;
	logic [31:0]       fail_q;
	logic [HADR_W:0]   clr_q;
	req_t              req_q;
	logic [BKT_W-1:0]  bkt_q;
	logic [BIN_W-1:0]  bin_q;
	logic [LINK_W-1:0] link_q;
	logic [LINK_W-1:0] head_q;
	logic [62:0]       thr_rd_q;
	logic              below;
	logic [LINK_W-1:0] rd_next_q;
	logic [63:0]       rd_lock_q, rd_call_q, rd_ref_q, rd_time_q;
	logic [5:0]        rd_evt_q;
	logic [31:0]       rd_cnt_q, rd_hist_q;
	logic              walk_mode_q;
	logic [HADR_W-1:0] hadr;
	logic [SLOT_W-1:0] rd_slot;
	logic [1:0]        mode_eff;
	logic [10:0]       limit_eff;
	logic [63:0]       sum;
	logic              hit;
	logic              full;
	logic [SLOT_W-1:0] new_slot;
	logic              rd_ok;

	assign mode_eff  = mode_q[1] ? MODE_HIST : mode_q;
	assign limit_eff = (limit_q < 11'(RECORDS)) ? limit_q : 11'(RECORDS);
	assign sum       = req.lock_addr + req.caller;
	assign hit       = (rd_lock_q == req_q.lock_addr) && (rd_call_q == req_q.caller);
	assign full      = alloc_q >= limit_eff;
	assign new_slot  = alloc_q[SLOT_W-1:0];
	assign rd_slot   = walk_mode_q ? SLOT_W'(link_q - LINK_W'(1)) : req_q.record_index;
	assign hadr      = {rd_slot, walk_mode_q ? bin_q : req_q.hist_bin};
	assign rd_ok     = 11'(req_q.record_index) < alloc_q;
	assign below     = (req_q.func == FUNC_RECORD) && (mode_eff != MODE_COUNT) &&
		(req_q.duration < thr_rd_q);

	assign sts.clear_done = clr_q[HADR_W];
	assign sts.below      = below;
	assign sts.link_end   = (link_q == '0);
	assign sts.hit        = (link_q != '0) && hit;
	assign sts.is_other   = (req_q.func != FUNC_RECORD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_COUNT;
			limit_q <= 11'd1024;
			alloc_q <= '0;
			fail_q  <= '0;
			clr_q   <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				if (cfg_idx == CFG_MODE) begin
					mode_q <= cfg_data[1:0];
				end else begin
					limit_q <= cfg_data;
				end
			end
			if (cmd.clear && !clr_q[HADR_W]) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.op == CMD_WRITE) begin
				result_valid <= (req_q.func != FUNC_UNUSED);
				if (req_q.func == FUNC_RECORD && !below && link_q == '0) begin
					if (full) begin
						fail_q <= fail_q + 1'b1;
					end else begin
						alloc_q <= alloc_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q    <= req;
			bkt_q    <= BKT_W'((sum >> 3) + 64'(req.event_req));
			bin_q    <= log2_bin(req.duration);
			thr_rd_q <= thr_mem[req.event_req[EVT_W-1:0]];
			walk_mode_q <= (req.func == FUNC_RECORD);
		end
		head_q <= head_mem[bkt_q];
		if (cmd.op == CMD_HEAD) begin
			link_q <= head_mem[bkt_q];
		end else if (cmd.op == CMD_WALK) begin
			link_q <= rd_next_q;
		end
		rd_next_q <= link_mem[rd_slot];
		rd_lock_q <= lock_mem[rd_slot];
		rd_call_q <= call_mem[rd_slot];
		rd_evt_q  <= evt_mem[rd_slot];
		rd_cnt_q  <= cnt_mem[rd_slot];
		rd_ref_q  <= ref_mem[rd_slot];
		rd_time_q <= time_mem[rd_slot];
		if (cmd.clear && !clr_q[HADR_W] && clr_q[HADR_W-1:EVT_W] == '0) begin
			thr_mem[clr_q[EVT_W-1:0]] <= '0;
		end else if (cmd.op == CMD_WRITE && req_q.func == FUNC_THRESH) begin
			thr_mem[req_q.event_req[EVT_W-1:0]] <= req_q.threshold_value;
		end
		if (cmd.clear) begin
			if (!clr_q[HADR_W]) begin
				hist_mem[clr_q[HADR_W-1:0]] <= '0;
				if (clr_q[HADR_W-1:BKT_W] == '0) begin
					head_mem[clr_q[BKT_W-1:0]] <= '0;
				end
			end
		end else if (cmd.op == CMD_WRITE && req_q.func == FUNC_RECORD && !below) begin
			if (link_q != '0) begin
				cnt_mem[rd_slot] <= rd_cnt_q + 1'b1;
				ref_mem[rd_slot] <= rd_ref_q + 64'(req_q.ref_count);
				if (mode_eff != MODE_COUNT) begin
					time_mem[rd_slot] <= rd_time_q + 64'(req_q.duration);
				end
				if (mode_eff == MODE_HIST) begin
					hist_mem[hadr] <= rd_hist_q + 1'b1;
				end
			end else if (!full) begin
				link_mem[new_slot] <= head_q;
				lock_mem[new_slot] <= req_q.lock_addr;
				call_mem[new_slot] <= req_q.caller;
				evt_mem[new_slot]  <= req_q.event_req;
				cnt_mem[new_slot]  <= 32'd1;
				ref_mem[new_slot]  <= 64'(req_q.ref_count);
				time_mem[new_slot] <= (mode_eff != MODE_COUNT) ? 64'(req_q.duration) : 64'd0;
				if (mode_eff == MODE_HIST) begin
					hist_mem[{new_slot, bin_q}] <= 32'd1;
				end
				head_mem[bkt_q] <= LINK_W'(new_slot) + LINK_W'(1);
			end
		end else begin
			rd_hist_q <= hist_mem[hadr];
		end
	end

	always_comb begin
		result = '0;
		if (req_q.func == FUNC_THRESH) begin
			result.status = ST_THRESH;
		end else if (req_q.func == FUNC_READ) begin
			result.status = ST_READ;
			if (rd_ok) begin
				result.out_lock   = rd_lock_q;
				result.out_caller = rd_call_q;
				result.out_event  = rd_evt_q;
				result.out_count  = rd_cnt_q;
				result.out_refcnt = rd_ref_q;
				result.out_time   = rd_time_q;
				result.out_hist   = rd_hist_q;
			end
		end else if (below) begin
			result.status = ST_BELOW;
		end else if (link_q != '0) begin
			result.status = ST_UPDATED;
		end else if (full) begin
			result.status = ST_FULL;
		end else begin
			result.status = ST_INSERTED;
		end
		result.records_in_use = alloc_q;
		result.fail_total     = fail_q;
		if (result.status == ST_INSERTED) begin
			result.records_in_use = alloc_q + 11'd1;
		end
		if (result.status == ST_FULL) begin
			result.fail_total = fail_q + 32'd1;
		end
	end
endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// Lock event statistics table testbench
// Drives record, threshold, read and unused-code items under random gaps
// through several mode and record limit settings, and checks every result
// against a cycle-free model of the hashed chains, counters and histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

class lock_stat_board;
	logic [10:0] head [0:2047];
	logic [10:0] link [0:1023];
	logic [63:0] s_lock [0:1023];
	logic [63:0] s_caller [0:1023];
	logic [5:0]  s_event [0:1023];
	logic [31:0] s_count [0:1023];
	logic [63:0] s_ref [0:1023];
	logic [63:0] s_time [0:1023];
	logic [31:0] hist [0:65535];
	logic [62:0] min_dur [0:63];
	int unsigned allocated;
	logic [31:0] lost;
	logic [1:0]  mode;
	logic [10:0] limit;
	lest_pkg::rsp_t pending [$];
	int errors;
	int status_seen [0:7];

	function new();
		foreach (head[i]) head[i] = '0;
		foreach (hist[i]) hist[i] = '0;
		foreach (min_dur[i]) min_dur[i] = '0;
		allocated = 0;
		lost = '0;
		mode = '0;
		limit = 11'd1024;
		errors = 0;
	endfunction

	function void write_reg(logic idx, logic [10:0] value);
		if (idx == lest_pkg::CFG_MODE) begin
			mode = value[1:0];
		end else begin
			limit = value;
		end
	endfunction

	function int dur_bin(logic [62:0] d);
		for (int i = 62; i > 0; i--) begin
			if (d[i]) begin
				return i;
			end
		end
		return 0;
	endfunction

	function lest_pkg::rsp_t record(lest_pkg::req_t r);
		lest_pkg::rsp_t e;
		int m;
		int b;
		int s;
		int steps;
		int lim;
		logic [63:0] sum;
		e = '0;
		m = (mode >= 2) ? 2 : int'(mode);
		if (m >= 1 && r.duration < min_dur[r.event_req]) begin
			e.status = lest_pkg::ST_BELOW;
			return e;
		end
		sum = r.lock_addr + r.caller;
		b = int'(((sum >> 3) + 64'(r.event_req)) % 64'd2048);
		s = int'(head[b]);
		steps = 0;
		while (s != 0 && steps < 1024) begin
			if (s_lock[s-1] == r.lock_addr && s_caller[s-1] == r.caller) begin
				s_count[s-1] += 32'd1;
				s_ref[s-1] += 64'(r.ref_count);
				if (m >= 1) begin
					s_time[s-1] += 64'(r.duration);
				end
				if (m >= 2) begin
					hist[(s-1)*64 + dur_bin(r.duration)] += 32'd1;
				end
				e.status = lest_pkg::ST_UPDATED;
				return e;
			end
			s = int'(link[s-1]);
			steps++;
		end
		lim = (limit < 11'd1024) ? int'(limit) : 1024;
		if (allocated >= lim) begin
			lost += 32'd1;
			e.status = lest_pkg::ST_FULL;
			return e;
		end
		s = allocated;
		allocated++;
		link[s] = head[b];
		s_lock[s] = r.lock_addr;
		s_caller[s] = r.caller;
		s_event[s] = r.event_req;
		s_count[s] = 32'd1;
		s_ref[s] = {32'd0, r.ref_count};
		s_time[s] = (m >= 1) ? {1'b0, r.duration} : 64'd0;
		if (m >= 2) begin
			hist[s*64 + dur_bin(r.duration)] = 32'd1;
		end
		head[b] = 11'(s + 1);
		e.status = lest_pkg::ST_INSERTED;
		return e;
	endfunction

	function void note_item(lest_pkg::req_t r);
		lest_pkg::rsp_t e;
		int s;
		e = '0;
		case (r.func)
			lest_pkg::FUNC_RECORD: begin
				e = record(r);
			end
			lest_pkg::FUNC_THRESH: begin
				min_dur[r.event_req] = r.threshold_value;
				e.status = lest_pkg::ST_THRESH;
			end
			lest_pkg::FUNC_READ: begin
				e.status = lest_pkg::ST_READ;
				s = int'(r.record_index);
				if (s < allocated) begin
					e.out_lock = s_lock[s];
					e.out_caller = s_caller[s];
					e.out_event = s_event[s];
					e.out_count = s_count[s];
					e.out_refcnt = s_ref[s];
					e.out_time = s_time[s];
					e.out_hist = hist[s*64 + int'(r.hist_bin)];
				end
			end
			default: begin
				return;
			end
		endcase
		e.records_in_use = allocated[10:0];
		e.fail_total = lost;
		pending.push_back(e);
	endfunction

	function bit differs(string name, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			if (errors < 10) begin
				$display("mismatch %s: expected %h, got %h at %0t", name, e, a, $time);
			end
			return 1;
		end
		return 0;
	endfunction

	function void check_result(lest_pkg::rsp_t a);
		lest_pkg::rsp_t e;
		bit bad;
		if (pending.size() == 0) begin
			if (errors < 10) begin
				$display("unexpected result item at %0t", $time);
			end
			errors++;
			return;
		end
		e = pending.pop_front();
		status_seen[e.status]++;
		bad = 0;
		bad |= differs("status", 64'(e.status), 64'(a.status));
		bad |= differs("out_lock", e.out_lock, a.out_lock);
		bad |= differs("out_caller", e.out_caller, a.out_caller);
		bad |= differs("out_event", 64'(e.out_event), 64'(a.out_event));
		bad |= differs("out_count", 64'(e.out_count), 64'(a.out_count));
		bad |= differs("out_refcnt", e.out_refcnt, a.out_refcnt);
		bad |= differs("out_time", e.out_time, a.out_time);
		bad |= differs("out_hist", 64'(e.out_hist), 64'(a.out_hist));
		bad |= differs("records_in_use", 64'(e.records_in_use), 64'(a.records_in_use));
		bad |= differs("fail_total", 64'(e.fail_total), 64'(a.fail_total));
		if (bad) begin
			errors++;
		end
	endfunction
endclass

module tb;
	logic clk;
	logic arst_n;
	logic start;
	lest_pkg::req_t req;
	logic busy;
	logic done;
	lest_pkg::rsp_t rsp;
	logic cfg_we;
	logic cfg_idx;
	logic [10:0] cfg_data;

	lock_stat_board board;
	logic [63:0] key_lock [0:63];
	logic [63:0] key_caller [0:63];
	logic [5:0]  key_event [0:63];
	int sent;

	lock_event_stat_table_top uut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("FAIL lock_event_stat_table_top");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_result(rsp);
		end
	end

	function logic [62:0] rand_dur();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[62:0] >> $urandom_range(0, 63);
	endfunction

	task automatic write_cfg(logic idx, logic [10:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= value;
		board.write_reg(idx, value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send(lest_pkg::req_t r);
		int gap;
		gap = $urandom_range(0, 5);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		forever begin
			@(posedge clk);
			if (!busy) begin
				break;
			end
		end
		board.note_item(r);
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
	endtask

	function lest_pkg::req_t mk(logic [1:0] f, int k, logic [62:0] d);
		lest_pkg::req_t r;
		r = '0;
		r.func = f;
		r.lock_addr = key_lock[k];
		r.caller = key_caller[k];
		r.event_req = key_event[k];
		r.ref_count = $urandom;
		r.duration = d;
		r.threshold_value = d;
		r.record_index = 10'($urandom_range(0, 1023));
		r.hist_bin = 6'($urandom_range(0, 63));
		return r;
	endfunction

	function lest_pkg::req_t rand_item();
		lest_pkg::req_t r;
		int k;
		int p;
		k = $urandom_range(0, 63);
		p = $urandom_range(0, 99);
		if (p < 8) begin
			key_lock[k] = {$urandom, $urandom};
			key_caller[k] = {$urandom, $urandom};
			key_event[k] = 6'($urandom);
		end
		if (p < 68) begin
			r = mk(lest_pkg::FUNC_RECORD, k, rand_dur());
		end else if (p < 76) begin
			r = mk(lest_pkg::FUNC_THRESH, k, rand_dur() >> $urandom_range(0, 8));
		end else if (p < 95) begin
			r = mk(lest_pkg::FUNC_READ, k, '0);
			if (board.allocated > 0 && $urandom_range(0, 3) != 0) begin
				r.record_index = 10'($urandom_range(0, board.allocated - 1));
				r.hist_bin = 6'(board.dur_bin(rand_dur()));
			end
		end else begin
			r = mk(lest_pkg::FUNC_UNUSED, k, rand_dur());
			r.lock_addr = {$urandom, $urandom};
		end
		return r;
	endfunction

	initial begin
		lest_pkg::req_t r;
		logic [1:0]  modes [0:5];
		int lims [0:5];
		board = new();
		sent = 0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_idx = lest_pkg::CFG_MODE;
		cfg_data = '0;
		arst_n = 1'b0;
		for (int i = 0; i < 64; i++) begin
			key_lock[i] = {$urandom, $urandom};
			key_caller[i] = {$urandom, $urandom};
			key_event[i] = 6'($urandom);
			if (i % 4 == 1) begin
				key_lock[i] = key_lock[i-1] + 64'd16384 * $urandom_range(1, 9);
				key_caller[i] = key_caller[i-1];
				key_event[i] = key_event[i-1];
			end
		end
		key_lock[0] = '1;
		key_caller[0] = '1;
		key_event[0] = 6'd63;
		key_lock[2] = '0;
		key_caller[2] = '0;
		key_event[2] = 6'd0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		write_cfg(lest_pkg::CFG_MODE, 11'd0);
		write_cfg(lest_pkg::CFG_LIMIT, 11'd1024);

		// Count-only mode: fresh keys, a repeat hit, a chain walk past a
		// colliding key, reads of used and unused slots, and the unused code.
		send(mk(lest_pkg::FUNC_RECORD, 0, '1));
		send(mk(lest_pkg::FUNC_RECORD, 2, '0));
		send(mk(lest_pkg::FUNC_RECORD, 0, '0));
		send(mk(lest_pkg::FUNC_RECORD, 4, 63'd7));
		send(mk(lest_pkg::FUNC_RECORD, 5, 63'd7));
		send(mk(lest_pkg::FUNC_RECORD, 4, 63'd7));
		r = mk(lest_pkg::FUNC_READ, 0, '0);
		r.record_index = 10'd0;
		send(r);
		r.record_index = 10'd1023;
		r.hist_bin = 6'd63;
		send(r);
		send(mk(lest_pkg::FUNC_UNUSED, 1, '1));
		drain();

		// Time mode: a duration just under, at and above the minimum.
		write_cfg(lest_pkg::CFG_MODE, 11'd1);
		send(mk(lest_pkg::FUNC_THRESH, 8, 63'd1000));
		send(mk(lest_pkg::FUNC_RECORD, 8, 63'd999));
		send(mk(lest_pkg::FUNC_RECORD, 8, 63'd1000));
		send(mk(lest_pkg::FUNC_RECORD, 8, 63'd5000));
		send(mk(lest_pkg::FUNC_THRESH, 8, '1));
		send(mk(lest_pkg::FUNC_RECORD, 8, '1));
		send(mk(lest_pkg::FUNC_THRESH, 8, '0));
		drain();

		// Histogram mode: zero and one both land in the lowest bin.
		write_cfg(lest_pkg::CFG_MODE, 11'd2);
		send(mk(lest_pkg::FUNC_RECORD, 12, '0));
		send(mk(lest_pkg::FUNC_RECORD, 12, 63'd1));
		send(mk(lest_pkg::FUNC_RECORD, 12, '1));
		r = mk(lest_pkg::FUNC_READ, 12, '0);
		r.record_index = 10'(board.allocated - 1);
		r.hist_bin = 6'd0;
		send(r);
		r.hist_bin = 6'd62;
		send(r);
		drain();

		modes = '{2'd0, 2'd1, 2'd2, 2'd2, 2'd1, 2'd2};
		lims = '{1024, 1024, 0, 1, 1024, 700};
		for (int p = 0; p < 6; p++) begin
			write_cfg(lest_pkg::CFG_MODE, 11'(modes[p]));
			write_cfg(lest_pkg::CFG_LIMIT,
				11'((lims[p] == 0) ? board.allocated + 4 : lims[p]));
			for (int n = 0; n < 165; n++) begin
				send(rand_item());
			end
			drain();
		end

		repeat (20) @(posedge clk);
		if (board.pending.size() != 0) begin
			board.errors++;
		end
		$display("Sent %0d items; %0d records allocated, %0d events lost to a full table.",
			sent, board.allocated, board.lost);
		$display("Results: %0d updates, %0d inserts, %0d below minimum, %0d full, %0d reads.",
			board.status_seen[0], board.status_seen[1], board.status_seen[2],
			board.status_seen[3], board.status_seen[5]);
		if (board.errors == 0) begin
			$display("PASS lock_event_stat_table_top");
		end else begin
			$display("FAIL lock_event_stat_table_top");
		end
		$finish;
	end
endmodule

>>> filelist.f
rtl/core/lest_pkg.sv
rtl/core/lest_ctrl.sv
rtl/core/lest_dp.sv
rtl/core/lock_event_stat_table_top.sv
sim/tb.sv
